// ===== rtl/hsvr_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB conversion package
// Pixel types, pipeline stage types and the fixed-point constants shared by
// the stages of the converter.
// ----------------------------------------------------------------------------
package hsvr_pkg;

  localparam int unsigned NumChan = 3;

  // Range limits of the input fields.
  localparam logic [8:0] HueMax    = 9'd359;
  localparam logic [6:0] PctMax    = 7'd100;
  localparam logic [5:0] SectorDeg = 6'd60;

  // Channel scale: v * 6000 is the value over the common denominator.
  localparam logic [12:0] ValScale = 13'd6000;

  // floor(n * 255 / 600000) equals floor(n * 17 / 40000).
  localparam int unsigned ScaledW  = 24;
  localparam logic [15:0] ChanDiv  = 16'd40000;
  localparam logic [16:0] RecipM   = 17'd107374;
  localparam int unsigned RecipSh  = 32;
  localparam int unsigned ProdW    = 41;
  localparam logic [8:0]  ChanMax  = 9'd255;

  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [6:0] saturation_pct;
    logic [6:0] value_pct;
  } hsv_pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  // First stage result: clamped levels, sector and the weight s*(60-tri)
  // is built from in the next stage.
  typedef struct packed {
    logic [6:0] sat;
    logic [6:0] val;
    sector_e    sector;
    logic [5:0] x_weight;
  } hsvr_s1_t;

  typedef logic [NumChan-1:0][ScaledW-1:0] hsvr_scaled_t;

endpackage

// ===== rtl/hsvr_sector.sv =====
// ----------------------------------------------------------------------------
// HSV sector stage
// Clamps the input fields, finds the 60 degree sector of the hue and the
// complement weight of the secondary component.
// ----------------------------------------------------------------------------
module hsvr_sector import hsvr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  hsv_pix_t pix_i,
  output logic     valid_o,
  output hsvr_s1_t s1_o
);

  logic [8:0] hue;
  logic [8:0] base;
  logic [8:0] offs;
  logic [5:0] frac;
  logic       odd;
  hsvr_s1_t   s1_d;
  hsvr_s1_t   s1_q;
  logic       valid_q;

  always_comb begin
    hue = (pix_i.hue_degrees > HueMax) ? HueMax : pix_i.hue_degrees;
    s1_d.sat = (pix_i.saturation_pct > PctMax) ? PctMax : pix_i.saturation_pct;
    s1_d.val = (pix_i.value_pct > PctMax) ? PctMax : pix_i.value_pct;
    priority if (hue < 9'd60) begin
      s1_d.sector = SecRedYel;
      base = 9'd0;
      odd = 1'b0;
    end else if (hue < 9'd120) begin
      s1_d.sector = SecYelGrn;
      base = 9'd60;
      odd = 1'b1;
    end else if (hue < 9'd180) begin
      s1_d.sector = SecGrnCyn;
      base = 9'd120;
      odd = 1'b0;
    end else if (hue < 9'd240) begin
      s1_d.sector = SecCynBlu;
      base = 9'd180;
      odd = 1'b1;
    end else if (hue < 9'd300) begin
      s1_d.sector = SecBluMag;
      base = 9'd240;
      odd = 1'b0;
    end else begin
      s1_d.sector = SecMagRed;
      base = 9'd300;
      odd = 1'b1;
    end
    offs = hue - base;
    frac = offs[5:0];
    // The triangle weight rises in even sectors and falls in odd ones; the
    // secondary channel loses s*(60-tri) from the full scale.
    s1_d.x_weight = odd ? frac : (SectorDeg - frac);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

// ===== rtl/hsvr_weight.sv =====
// ----------------------------------------------------------------------------
// HSV channel weight stages
// Forms each channel's level over the common denominator, already scaled by
// seventeen, in two register stages.
// ----------------------------------------------------------------------------
module hsvr_weight import hsvr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  hsvr_s1_t     s1_i,
  output logic         valid_o,
  output hsvr_scaled_t scaled_o
);

  logic [12:0] prod_x;
  logic [12:0] prod_z;
  logic [12:0] p_x;
  logic [12:0] p_z;
  logic [12:0] p_chan [NumChan];
  logic [16:0] p17_d  [NumChan];
  logic [16:0] p17_q  [NumChan];
  logic [6:0]  val_q;
  logic        valid2_q;
  hsvr_scaled_t n_d;
  hsvr_scaled_t n_q;
  logic        valid3_q;

  always_comb begin
    prod_x = 13'(s1_i.sat) * 13'(s1_i.x_weight);
    prod_z = 13'(s1_i.sat) * 13'(SectorDeg);
    p_x = ValScale - prod_x;
    p_z = ValScale - prod_z;
    // Primary channel keeps the full value, the zero channel only the offset.
    unique case (s1_i.sector)
      SecRedYel: begin
        p_chan[0] = ValScale; p_chan[1] = p_x;      p_chan[2] = p_z;
      end
      SecYelGrn: begin
        p_chan[0] = p_x;      p_chan[1] = ValScale; p_chan[2] = p_z;
      end
      SecGrnCyn: begin
        p_chan[0] = p_z;      p_chan[1] = ValScale; p_chan[2] = p_x;
      end
      SecCynBlu: begin
        p_chan[0] = p_z;      p_chan[1] = p_x;      p_chan[2] = ValScale;
      end
      SecBluMag: begin
        p_chan[0] = p_x;      p_chan[1] = p_z;      p_chan[2] = ValScale;
      end
      default: begin
        p_chan[0] = ValScale; p_chan[1] = p_z;      p_chan[2] = p_x;
      end
    endcase
    for (int c = 0; c < NumChan; c++) begin
      p17_d[c] = ({4'b0, p_chan[c]} << 4) + {4'b0, p_chan[c]};
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      n_d[c] = ScaledW'(val_q) * ScaledW'(p17_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid_i;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= s1_i.val;
      p17_q <= p17_d;
      n_q   <= n_d;
    end
  end

  assign valid_o  = valid3_q;
  assign scaled_o = n_q;

endmodule

// ===== rtl/hsvr_div.sv =====
// ----------------------------------------------------------------------------
// HSV channel byte stages
// Divides each scaled level by the channel denominator with a reciprocal
// multiply, then corrects the quotient by one compare and saturates.
// ----------------------------------------------------------------------------
module hsvr_div import hsvr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  hsvr_scaled_t scaled_i,
  output logic         valid_o,
  output rgb_pix_t     pix_o
);

  logic [ProdW-1:0]   prod   [NumChan];
  logic [8:0]         q0_d   [NumChan];
  logic [8:0]         q0_q   [NumChan];
  hsvr_scaled_t       n_q;
  logic               valid4_q;
  logic [ScaledW:0]   rem    [NumChan];
  logic [8:0]         q_sum  [NumChan];
  logic [7:0]         byte_d [NumChan];
  rgb_pix_t           pix_q;
  logic               valid5_q;

  // The reciprocal is rounded down, so the estimate is exact or one short.
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod[c] = ProdW'(scaled_i[c]) * ProdW'(RecipM);
      q0_d[c] = prod[c][RecipSh +: 9];
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rem[c]   = {1'b0, n_q[c]} - ((ScaledW+1)'(q0_q[c]) * (ScaledW+1)'(ChanDiv));
      q_sum[c] = q0_q[c] + ((rem[c] >= (ScaledW+1)'(ChanDiv)) ? 9'd1 : 9'd0);
      byte_d[c] = (q_sum[c] > ChanMax) ? ChanMax[7:0] : q_sum[c][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
      valid5_q <= 1'b0;
    end else if (en_i) begin
      valid4_q <= valid_i;
      valid5_q <= valid4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q        <= q0_d;
      n_q         <= scaled_i;
      pix_q.red   <= byte_d[0];
      pix_q.green <= byte_d[1];
      pix_q.blue  <= byte_d[2];
    end
  end

  assign valid_o = valid5_q;
  assign pix_o   = pix_q;

endmodule

// ===== rtl/hsv_to_rgb.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one pixel of hue, saturation and value into three channel bytes.
// ----------------------------------------------------------------------------
// The converter takes one pixel in every clock while it is not stalled and
// passes it through its five register stages: sector search, channel weights,
// value product, reciprocal multiply and quotient correction. Out-of-range
// hue, saturation and value are clamped to 359, 100 and 100. A stall on a
// valid output holds every stage at once, so the input is stalled in the
// same cycle and nothing is dropped or repeated. Reset clears only the valid
// bits; there is no clearing pass.
module hsv_to_rgb import hsvr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hsv_pix_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rgb_pix_t out_data_o
);

  logic         advance;
  logic         s1_valid;
  hsvr_s1_t     s1;
  logic         w_valid;
  hsvr_scaled_t scaled;

  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  hsvr_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_valid_i),
    .pix_i   (in_data_i),
    .valid_o (s1_valid),
    .s1_o    (s1)
  );

  hsvr_weight u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .valid_i  (s1_valid),
    .s1_i     (s1),
    .valid_o  (w_valid),
    .scaled_o (scaled)
  );

  hsvr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (w_valid),
    .scaled_i(scaled),
    .valid_o (out_valid_o),
    .pix_o   (out_data_o)
  );

  // A transfer in reaches the output once every stage has advanced without a stall.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o
      ##1 !in_stall_o |=> out_valid_o)
    else $error("transfer in did not reach the output after five stages");

  // Zero value gives black on all channels.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.value_pct == 7'd0) ##1 !in_stall_o
      ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o |=> out_data_o == '0)
    else $error("zero value did not give black");

  // Zero saturation at full value gives white on all channels.
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.saturation_pct == 7'd0 &&
     in_data_i.value_pct >= PctMax) ##1 !in_stall_o ##1 !in_stall_o
      ##1 !in_stall_o ##1 !in_stall_o |=> out_data_o == '1)
    else $error("full grey level did not give white");

endmodule

// ===== tb/sv/hsv_to_rgb_test.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed and random pixels through the converter with random idle
// cycles on both sides, predicts each colour from the pixel alone and checks
// every output transfer, in order, against the oldest predicted colour.
// ----------------------------------------------------------------------------
module hsv_to_rgb_test;
  import hsvr_pkg::*;

  localparam longint unsigned FracDen  = 600000;
  localparam longint unsigned ByteFull = 255;
  localparam int unsigned     IdlePct  = 13;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  hsv_pix_t in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rgb_pix_t out_data_o;

  // Cleared during the stretch in which neither side idles.
  bit       gaps_on = 1'b1;
  int       fail_count = 0;
  rgb_pix_t colour_queue[$];

  hsv_to_rgb u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] channel_byte(longint unsigned level);
    longint unsigned q;
    q = (level * ByteFull) / FracDen;
    if (q > ByteFull) begin
      q = ByteFull;
    end
    return q[7:0];
  endfunction

  // All levels are kept as exact integers over a denominator of 600000.
  function automatic rgb_pix_t predict_colour(hsv_pix_t pix);
    int unsigned     hue;
    int unsigned     sat;
    int unsigned     val;
    int unsigned     folded;
    int unsigned     weight;
    longint unsigned chroma;
    longint unsigned xval;
    longint unsigned base;
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    rgb_pix_t        res;
    hue = 32'((pix.hue_degrees > HueMax) ? HueMax : pix.hue_degrees);
    sat = 32'((pix.saturation_pct > PctMax) ? PctMax : pix.saturation_pct);
    val = 32'((pix.value_pct > PctMax) ? PctMax : pix.value_pct);
    folded = hue % (2 * SectorDeg);
    weight = (folded >= SectorDeg) ? (2 * SectorDeg - folded) : folded;
    chroma = longint'(sat) * val * SectorDeg;
    xval   = longint'(sat) * val * weight;
    base   = longint'(val) * (FracDen / PctMax) - chroma;
    case (sector_e'(hue / SectorDeg))
      SecRedYel: begin r = chroma; g = xval;   b = 0;      end
      SecYelGrn: begin r = xval;   g = chroma; b = 0;      end
      SecGrnCyn: begin r = 0;      g = chroma; b = xval;   end
      SecCynBlu: begin r = 0;      g = xval;   b = chroma; end
      SecBluMag: begin r = xval;   g = 0;      b = chroma; end
      default:   begin r = chroma; g = 0;      b = xval;   end
    endcase
    res.red   = channel_byte(r + base);
    res.green = channel_byte(g + base);
    res.blue  = channel_byte(b + base);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input logic [8:0] hue, input logic [6:0] sat,
                            input logic [6:0] val);
    hsv_pix_t pix;
    pix = '{hue_degrees: hue, saturation_pct: sat, value_pct: val};
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pix;
    do @(posedge clk_i); while (in_stall_o);
    colour_queue.push_back(predict_colour(pix));
    @(negedge clk_i);
  endtask

  // Mostly in range; roughly one field in seven spans the whole port width.
  task automatic send_random_pixel();
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] val;
    hue = 9'(($urandom_range(6) == 0) ? $urandom_range(511) : $urandom_range(HueMax));
    sat = 7'(($urandom_range(6) == 0) ? $urandom_range(127) : $urandom_range(PctMax));
    val = 7'(($urandom_range(6) == 0) ? $urandom_range(127) : $urandom_range(PctMax));
    send_pixel(hue, sat, val);
  endtask

  task automatic test_sector_edges();
    send_pixel(9'd0,   7'd100, 7'd100);
    send_pixel(9'd59,  7'd100, 7'd100);
    send_pixel(9'd60,  7'd100, 7'd100);
    send_pixel(9'd119, 7'd100, 7'd100);
    send_pixel(9'd120, 7'd100, 7'd100);
    send_pixel(9'd179, 7'd100, 7'd100);
    send_pixel(9'd180, 7'd100, 7'd100);
    send_pixel(9'd239, 7'd100, 7'd100);
    send_pixel(9'd240, 7'd100, 7'd100);
    send_pixel(9'd299, 7'd100, 7'd100);
    send_pixel(9'd300, 7'd100, 7'd100);
    send_pixel(9'd359, 7'd100, 7'd100);
  endtask

  task automatic test_clamping();
    send_pixel(9'd511, 7'd127, 7'd127);
    send_pixel(9'd360, 7'd50,  7'd50);
    send_pixel(9'd200, 7'd101, 7'd80);
    send_pixel(9'd100, 7'd60,  7'd101);
  endtask

  task automatic test_grey_levels();
    send_pixel(9'd123, 7'd0,   7'd77);
    send_pixel(9'd45,  7'd88,  7'd0);
    send_pixel(9'd0,   7'd0,   7'd100);
    send_pixel(9'd359, 7'd100, 7'd1);
    send_pixel(9'd0,   7'd0,   7'd0);
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    repeat (count) send_random_pixel();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_gaps(input int count);
    repeat (count) send_random_pixel();
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    rgb_pix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (colour_queue.size() == 0) begin
        $display("%0t: unexpected output transfer, actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = colour_queue.pop_front();
        if (out_data_o.red !== want.red) begin
          $display("%0t: red mismatch, expected %0d, actual %0d",
                   $time, want.red, out_data_o.red);
          fail_count++;
        end
        if (out_data_o.green !== want.green) begin
          $display("%0t: green mismatch, expected %0d, actual %0d",
                   $time, want.green, out_data_o.green);
          fail_count++;
        end
        if (out_data_o.blue !== want.blue) begin
          $display("%0t: blue mismatch, expected %0d, actual %0d",
                   $time, want.blue, out_data_o.blue);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_sector_edges();
    test_clamping();
    test_grey_levels();
    test_back_to_back(300);
    test_random_gaps(730);
    in_valid_i <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk_i);
    // Allow for anything still in flight through the five stages.
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hsvr_pkg.sv
rtl/hsvr_sector.sv
rtl/hsvr_weight.sv
rtl/hsvr_div.sv
rtl/hsv_to_rgb.sv
tb/sv/hsv_to_rgb_test.sv
